// ----- hdl/marker_framed_packet_receiver_core_assert.svh -----
// assertion macros used by the checker file of the packet receiver
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef MARKER_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define MARKER_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define MFPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mfpr_pkg.sv -----
// shared types and constants of the marker framed packet receiver
// no dependencies
package mfpr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF  = 32;
  localparam int unsigned PAYLOAD_BYTES_DEF = 3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_COMMAND = 2'd2;

  localparam logic [7:0] START_BYTE_RST  = 8'h3C;
  localparam logic [7:0] END_BYTE_RST    = 8'h3E;
  localparam logic [7:0] ACK_COMMAND_RST = 8'hD4;

  localparam int unsigned LEN_W   = 5;
  localparam logic [LEN_W-1:0] LEN_MAX = 5'd31;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] ack_command;
  } cfg_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic             ack_seen;
    logic             checksum_ok;
    logic [15:0]      switch_word;
    logic [7:0]       command_code;
    logic [LEN_W-1:0] frame_length;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

// ----- hdl/mfpr_deframer.sv -----
// frame state, byte store and result forming for one registered byte
// depends on mfpr_pkg
module mfpr_deframer #(
  parameter int unsigned BUFFER_BYTES  = mfpr_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned PAYLOAD_BYTES = mfpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        byte_i,
  input  logic              advance_i,
  input  mfpr_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output mfpr_pkg::result_t res_o
);
  import mfpr_pkg::*;

  localparam int unsigned STORE_DEPTH = (PAYLOAD_BYTES + 1 > 3) ? PAYLOAD_BYTES + 1 : 3;
  localparam int unsigned IDX_W       = $clog2(BUFFER_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_BYTES - 1);

  logic             in_frame_q, in_frame_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       store_q [STORE_DEPTH];
  logic [7:0]       store_d [STORE_DEPTH];
  logic [7:0]       store_clr [STORE_DEPTH];
  logic             is_end;
  logic [7:0]       sum;
  logic [IDX_W:0]   idx_ext;

  assign is_end      = in_frame_q && (byte_i == cfg_i.end_byte);
  assign res_valid_o = valid_i && is_end;
  assign idx_ext     = {1'b0, idx_q};

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_clr[k] = (32'(idx_q) == 32'(k)) ? 8'h00 : store_q[k];
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    store_d    = store_q;
    if (advance_i && valid_i) begin
      if (!in_frame_q) begin
        in_frame_d = (byte_i == cfg_i.start_byte);
      end else if (!is_end) begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
          if (32'(idx_q) == 32'(k)) begin
            store_d[k] = byte_i;
          end
        end
        idx_d = (idx_q == IDX_LAST) ? idx_q : idx_q + IDX_W'(1);
      end else begin
        store_d    = store_clr;
        in_frame_d = 1'b0;
        idx_d      = '0;
      end
    end
  end

  always_comb begin
    sum = 8'h00;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      sum = sum + store_clr[k];
    end
  end

  always_comb begin
    res_o.frame_length = (idx_ext > (IDX_W + 1)'(LEN_MAX)) ? LEN_MAX : LEN_W'(idx_q);
    res_o.command_code = store_clr[0];
    res_o.switch_word  = {store_clr[2], store_clr[1]};
    res_o.checksum_ok  = (sum == store_clr[PAYLOAD_BYTES]);
    res_o.ack_seen     = res_o.checksum_ok && (store_clr[0] == cfg_i.ack_command);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      for (int k = 0; k < STORE_DEPTH; k++) begin
        store_q[k] <= 8'h00;
      end
    end else begin
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      store_q    <= store_d;
    end
  end

endmodule

// ----- hdl/marker_framed_packet_receiver_core.sv -----
// path: input byte register, then deframer, then registered output result
// throughput: one byte per cycle; a frame-ending byte waits in the input
//   register only while the single output register holds an untaken result
// reset: async active low; idle, index and store cleared, markers to defaults
// depends on mfpr_pkg and mfpr_deframer
module marker_framed_packet_receiver_core #(
  parameter int unsigned BUFFER_BYTES  = mfpr_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned PAYLOAD_BYTES = mfpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // frame_length, command_code, switch_word, checksum_ok, ack_seen, zero pad
  output logic [mfpr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mfpr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);
  import mfpr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  result_t    res;
  logic       res_valid;
  logic       out_free;
  logic       advance;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = !res_valid || out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_q};

  mfpr_deframer #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_q),
    .byte_i     (in_byte_q),
    .advance_i  (advance),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_BYTE:  cfg_d.start_byte  = cfg_data_i;
        CFG_END_BYTE:    cfg_d.end_byte    = cfg_data_i;
        CFG_ACK_COMMAND: cfg_d.ack_command = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (res_valid && advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= START_BYTE_RST;
      cfg_q.end_byte    <= END_BYTE_RST;
      cfg_q.ack_command <= ACK_COMMAND_RST;
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (res_valid && advance) begin
      out_q <= res;
    end
  end

endmodule

// ----- hdl/mfpr_checker.sv -----
// port-level checks of the packet receiver, bound to its top level
// depends on marker_framed_packet_receiver_core_assert.svh
`include "marker_framed_packet_receiver_core_assert.svh"

module mfpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `MFPR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed or dropped while stalled")
  `MFPR_ASSERT_IMP(a_ack_needs_ok, m_axis_tvalid && m_axis_tdata[30], m_axis_tdata[29], "ack flag without checksum flag")
  `MFPR_ASSERT_IMP(a_pad_zero, m_axis_tvalid, !m_axis_tdata[31], "pad bit of result set")
  `MFPR_ASSERT_IMP(a_empty_cmd, m_axis_tvalid && (m_axis_tdata[4:0] == 5'd0), m_axis_tdata[12:5] == 8'd0, "empty frame with nonzero command")

endmodule

bind marker_framed_packet_receiver_core mfpr_checker u_mfpr_checker (.*);

// ----- tb/tb_marker_framed_packet_receiver_core.sv -----
// testbench for marker_framed_packet_receiver_core: drives rx bytes and marker settings,
// predicts frame results in a local deframer or a directed table and checks the result stream
// depends on mfpr_pkg and the receiver rtl
`timescale 1ns / 100ps

module tb_marker_framed_packet_receiver_core;
  import mfpr_pkg::*;

  localparam int unsigned STORE_DEPTH = PAYLOAD_BYTES_DEF + 1;
  localparam int unsigned DRAIN_CYC   = 8;
  localparam int unsigned HOLD_CYC    = 200;
  localparam int unsigned NUM_DIR     = 25;

  typedef struct packed {
    logic [7:0] rx;
    logic       chk;
    result_t    res;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{8'h3E, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'h3E, 1'b1, '{ack_seen: 1'b0, checksum_ok: 1'b1, switch_word: 16'h0000,
                     command_code: 8'h00, frame_length: 5'd0}},
    '{8'h3C, 1'b0, '0},
    '{8'hD4, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'hD7, 1'b0, '0},
    '{8'h3E, 1'b1, '{ack_seen: 1'b1, checksum_ok: 1'b1, switch_word: 16'h0201,
                     command_code: 8'hD4, frame_length: 5'd4}},
    '{8'h3C, 1'b0, '0},
    '{8'h10, 1'b0, '0},
    '{8'h20, 1'b0, '0},
    '{8'h0E, 1'b0, '0},
    // checksum byte equals the end marker and closes the frame
    '{8'h3E, 1'b1, '{ack_seen: 1'b0, checksum_ok: 1'b0, switch_word: 16'h0E20,
                     command_code: 8'h10, frame_length: 5'd3}},
    '{8'h3C, 1'b0, '0},
    // start marker inside a frame is plain data
    '{8'h3C, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h3A, 1'b0, '0},
    '{8'h3E, 1'b1, '{ack_seen: 1'b0, checksum_ok: 1'b1, switch_word: 16'hFFFF,
                     command_code: 8'h3C, frame_length: 5'd4}},
    // short frame reports stale bytes
    '{8'h3C, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'h3E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = 8'h00;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = CFG_START_BYTE;
  logic [7:0]             cfg_data_i    = 8'h00;

  // predictor state
  cfg_t        mk = '{START_BYTE_RST, END_BYTE_RST, ACK_COMMAND_RST};
  bit          frm_open = 1'b0;
  int unsigned frm_idx = 0;
  logic [7:0]  frm_store [STORE_DEPTH] = '{default: 8'h00};

  result_t     frame_q [$];
  int unsigned err_cnt = 0;
  int unsigned used_items = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 64;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;

  marker_framed_packet_receiver_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [7:0] sum;
    sum = 8'h00;
    r = '0;
    if (!frm_open) begin
      frm_open = (b == mk.start_byte);
      return 1'b0;
    end
    if (b != mk.end_byte) begin
      if (frm_idx < STORE_DEPTH) frm_store[frm_idx] = b;
      if (frm_idx < BUFFER_BYTES_DEF - 1) frm_idx++;
      return 1'b0;
    end
    if (frm_idx < STORE_DEPTH) frm_store[frm_idx] = 8'h00;
    r.frame_length = (frm_idx > LEN_MAX) ? LEN_MAX : LEN_W'(frm_idx);
    frm_open = 1'b0;
    frm_idx = 0;
    for (int k = 0; k < PAYLOAD_BYTES_DEF; k++) sum += frm_store[k];
    r.command_code = frm_store[0];
    r.switch_word = {frm_store[2], frm_store[1]};
    r.checksum_ok = (sum == frm_store[PAYLOAD_BYTES_DEF]);
    r.ack_seen = r.checksum_ok && (frm_store[0] == mk.ack_command);
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (frm_open || b == mk.start_byte) used_items++;
    if (deframe_byte(b, r)) frame_q.push_back(typed ? typed_res : r);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START_BYTE:  mk.start_byte = val;
      CFG_END_BYTE:    mk.end_byte = val;
      CFG_ACK_COMMAND: mk.ack_command = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic send_frames(input int unsigned n_items);
    logic [7:0]  frm [$];
    int unsigned kind;
    int unsigned plen;
    logic [7:0]  pb;
    logic [7:0]  sum;
    int unsigned stop_at = used_items + n_items;
    while (used_items < stop_at) begin
      kind = $urandom_range(99);
      frm.delete();
      sum = 8'h00;
      if (kind < 8) begin
        repeat ($urandom_range(1, 4)) frm.push_back(8'($urandom));
      end else begin
        frm.push_back(mk.start_byte);
        if (kind < 16) plen = $urandom_range(0, 5);
        else if (kind < 24) plen = $urandom_range(28, 40);
        else if (kind < 40) plen = $urandom_range(0, 3);
        else plen = ($urandom_range(99) < 70) ? 4 : $urandom_range(5, 8);
        for (int k = 0; k < plen; k++) begin
          if (k == 0 && $urandom_range(1) == 1) pb = mk.ack_command;
          else if (k == PAYLOAD_BYTES_DEF && $urandom_range(99) < 80) pb = sum;
          else pb = 8'($urandom);
          if (k < PAYLOAD_BYTES_DEF) sum += pb;
          frm.push_back(pb);
        end
        // unterminated frames run into the next one
        if (kind >= 16) frm.push_back(mk.end_byte);
      end
      foreach (frm[k]) send_byte(frm[k], 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (frame_q.size() == 0) begin
        $error("unexpected result item %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = frame_q.pop_front();
        if (got.frame_length !== want.frame_length) begin
          $error("frame_length expected %0d got %0d", want.frame_length, got.frame_length);
          err_cnt++;
        end
        if (got.command_code !== want.command_code) begin
          $error("command_code expected %h got %h", want.command_code, got.command_code);
          err_cnt++;
        end
        if (got.switch_word !== want.switch_word) begin
          $error("switch_word expected %h got %h", want.switch_word, got.switch_word);
          err_cnt++;
        end
        if (got.checksum_ok !== want.checksum_ok) begin
          $error("checksum_ok expected %b got %b", want.checksum_ok, got.checksum_ok);
          err_cnt++;
        end
        if (got.ack_seen !== want.ack_seen) begin
          $error("ack_seen expected %b got %b", want.ack_seen, got.ack_seen);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    cfg_t nxt;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 3) ? 0 : 64;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 3) ? 0 : 30;
      if (ph == 0) begin
        for (int i = 0; i < NUM_DIR; i++)
          send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].chk, DIR_ROWS[i].res);
        send_frames(380);
      end else begin
        settle();
        case (ph)
          1: nxt = '{8'h00, 8'hFF, 8'h00};
          2: nxt = '{8'hFF, 8'h00, 8'hFF};
          default: nxt = cfg_t'(24'($urandom));
        endcase
        cfg_write(CFG_START_BYTE, nxt.start_byte);
        cfg_write(CFG_END_BYTE, nxt.end_byte);
        cfg_write(CFG_ACK_COMMAND, nxt.ack_command);
        cfg_valid_i <= 1'b0;
        if (ph == 3) hold_req = 1'b1;
        send_frames((ph == 2) ? 370 : 400);
      end
    end
    settle();
    if (err_cnt == 0 && frame_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mfpr_pkg.sv
hdl/mfpr_deframer.sv
hdl/marker_framed_packet_receiver_core.sv
hdl/mfpr_checker.sv
tb/tb_marker_framed_packet_receiver_core.sv
